// File: rtl/core/mhs_pkg.sv
// ============================================================================
// mhs_pkg
// Shared constants and controller/datapath interface types for the
// min-heap descending sorter.
// ============================================================================
`default_nettype none

package mhs_pkg;

    localparam int MAX_KEYS    = 64;
    localparam int KEY_W       = 32;
    localparam int STEP_W      = 10;
    localparam int ADDR_W      = $clog2(MAX_KEYS);
    localparam int CNT_W       = $clog2(MAX_KEYS + 1);
    localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_W + STEP_W + 7) / 8) * 8;
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    typedef struct packed {
        logic load;
        logic build_rd;
        logic build_ld;
        logic sift_rd;
        logic sift_cmp;
        logic swap_rd;
        logic swap_ld;
        logic next_build;
        logic start_sort;
        logic next_sort;
        logic emit_rd;
        logic emit_beat;
    } mhs_cmd_t;

    typedef struct packed {
        logic start;
        logic multi;
        logic swap;
        logic k_zero;
        logic i_one;
        logic emit_last;
    } mhs_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mhs_ram.sv
// ============================================================================
// mhs_ram
// Generic RAM: one write port, two read ports with enable and registered data.
// ============================================================================
`default_nettype none

module mhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic                     re_b,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mhs_dp.sv
// ============================================================================
// mhs_dp
// Datapath: key store, sift-down compare/swap, loop indexes and step count.
// ============================================================================
`default_nettype none

module mhs_dp
    import mhs_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mhs_cmd_t        cmd,
    output mhs_stat_t            stat,
    input  wire logic            in_valid,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic            in_last,
    output logic [KEY_W-1:0]     out_key,
    output logic [STEP_W-1:0]    out_steps
);

    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [ADDR_W-1:0] k_reg,       k_next;
    logic [ADDR_W-1:0] i_reg,       i_next;
    logic [ADDR_W-1:0] j_reg,       j_next;
    logic [ADDR_W-1:0] node_reg,    node_next;
    logic [CNT_W-1:0]  size_reg,    size_next;
    logic [KEY_W-1:0]  carry_reg,   carry_next;
    logic [STEP_W-1:0] steps_reg,   steps_next;

    logic              full;
    logic              store;
    logic [CNT_W-1:0]  n_in;
    logic [ADDR_W:0]   left;
    logic [ADDR_W+1:0] right;
    logic              left_ok;
    logic              right_ok;
    logic              pick_left;
    logic              pick_right;
    logic [KEY_W-1:0]  best;
    logic [KEY_W-1:0]  child;
    logic [ADDR_W-1:0] pick_idx;
    logic              swap;
    logic              emit_last;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re_a;
    logic              re_b;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [KEY_W-1:0]  qa;
    logic [KEY_W-1:0]  qb;

    assign full  = (count_reg == CNT_W'(MAX_KEYS));
    assign store = cmd.load && in_valid && !full;
    assign n_in  = full ? count_reg : count_reg + CNT_W'(1);

    // child indexes 2i+1 and 2i+2
    assign left     = {node_reg, 1'b1};
    assign right    = {1'b0, node_reg, 1'b0} + (ADDR_W+2)'(2);
    assign left_ok  = ({1'b0, left} < (ADDR_W+2)'(size_reg));
    assign right_ok = (right < (ADDR_W+2)'(size_reg));

    assign pick_left  = left_ok && ($signed(qa) < $signed(carry_reg));
    assign best       = pick_left ? qa : carry_reg;
    assign pick_right = right_ok && ($signed(qb) < $signed(best));
    assign swap       = pick_left || pick_right;
    assign child      = pick_right ? qb : qa;
    assign pick_idx   = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

    assign emit_last = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);

    assign stat.start     = cmd.load && in_valid && in_last;
    assign stat.multi     = (n_in > CNT_W'(1));
    assign stat.swap      = swap;
    assign stat.k_zero    = (k_reg == '0);
    assign stat.i_one     = (i_reg == ADDR_W'(1));
    assign stat.emit_last = emit_last;

    always_comb
    begin
        we    = store || cmd.sift_cmp || cmd.swap_ld;
        waddr = node_reg;
        wdata = swap ? child : carry_reg;
        if (cmd.load)
        begin
            waddr = count_reg[ADDR_W-1:0];
            wdata = in_key;
        end
        else if (cmd.swap_ld)
        begin
            waddr = i_reg;
            wdata = qa;
        end

        re_a    = cmd.build_rd || cmd.sift_rd || cmd.swap_rd || cmd.emit_rd;
        re_b    = cmd.sift_rd || cmd.swap_rd;
        raddr_a = j_reg;
        if (cmd.build_rd)
        begin
            raddr_a = k_reg;
        end
        else if (cmd.sift_rd)
        begin
            raddr_a = left[ADDR_W-1:0];
        end
        else if (cmd.swap_rd)
        begin
            raddr_a = '0;
        end
        raddr_b = cmd.sift_rd ? right[ADDR_W-1:0] : i_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        node_next  = node_reg;
        size_next  = size_reg;
        carry_next = carry_reg;
        steps_next = steps_reg;

        if (store)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (stat.start)
        begin
            k_next     = ADDR_W'(n_in >> 1) - ADDR_W'(1);
            steps_next = '0;
        end
        if (cmd.next_build)
        begin
            k_next = k_reg - ADDR_W'(1);
        end
        if (cmd.start_sort)
        begin
            i_next = ADDR_W'(count_reg - CNT_W'(1));
        end
        if (cmd.next_sort)
        begin
            i_next = i_reg - ADDR_W'(1);
        end
        if (cmd.build_ld)
        begin
            carry_next = qa;
            node_next  = k_reg;
            size_next  = count_reg;
        end
        if (cmd.swap_ld)
        begin
            carry_next = qb;
            node_next  = '0;
            size_next  = CNT_W'(i_reg);
        end
        if (cmd.sift_rd && (steps_reg != STEP_MAX))
        begin
            steps_next = steps_reg + STEP_W'(1);
        end
        if (cmd.sift_cmp && swap)
        begin
            node_next = pick_idx;
        end
        if (cmd.emit_beat)
        begin
            if (emit_last)
            begin
                j_next     = '0;
                count_next = '0;
                steps_next = '0;
            end
            else
            begin
                j_next = j_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            node_reg  <= '0;
            size_reg  <= '0;
            steps_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            node_reg  <= node_next;
            size_reg  <= size_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    mhs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_heap_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (qa),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (qb)
    );

    assign out_key   = qa;
    assign out_steps = steps_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count above capacity");

    a_node_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sift_rd |-> ({1'b0, node_reg} < (ADDR_W+1)'(size_reg)))
        else $error("sift node outside heap");

    a_swap_smaller: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sift_cmp && swap) |-> ($signed(child) < $signed(carry_reg)))
        else $error("swap with child not strictly smaller");

    a_steps_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sift_rd |=> (steps_reg >= $past(steps_reg)))
        else $error("step count went backward during sift");

endmodule

`default_nettype wire

// File: rtl/core/mhs_ctrl.sv
// ============================================================================
// mhs_ctrl
// Controller: sequences load, heap build, root swaps, sift-down and output.
// ============================================================================
`default_nettype none

module mhs_ctrl
    import mhs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mhs_stat_t stat,
    input  wire logic      out_ready,
    output mhs_cmd_t       cmd,
    output logic           in_ready,
    output logic           out_valid
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_BUILD_RD  = 9'b000000010,
        ST_BUILD_LD  = 9'b000000100,
        ST_SIFT_RD   = 9'b000001000,
        ST_SIFT_CMP  = 9'b000010000,
        ST_SWAP_RD   = 9'b000100000,
        ST_SWAP_LD   = 9'b001000000,
        ST_EMIT_RD   = 9'b010000000,
        ST_EMIT_WAIT = 9'b100000000
    } mhs_state_t;

    mhs_state_t state_reg, state_next;
    logic       sorting_reg, sorting_next;

    always_comb
    begin
        state_next   = state_reg;
        sorting_next = sorting_reg;
        cmd          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = 1'b1;
                if (stat.start)
                begin
                    sorting_next = 1'b0;
                    state_next   = stat.multi ? ST_BUILD_RD : ST_EMIT_RD;
                end
            end
            ST_BUILD_RD:
            begin
                cmd.build_rd = 1'b1;
                state_next   = ST_BUILD_LD;
            end
            ST_BUILD_LD:
            begin
                cmd.build_ld = 1'b1;
                state_next   = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd.sift_rd = 1'b1;
                state_next  = ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd.sift_cmp = 1'b1;
                if (stat.swap)
                begin
                    state_next = ST_SIFT_RD;
                end
                else if (!sorting_reg)
                begin
                    if (stat.k_zero)
                    begin
                        cmd.start_sort = 1'b1;
                        sorting_next   = 1'b1;
                        state_next     = ST_SWAP_RD;
                    end
                    else
                    begin
                        cmd.next_build = 1'b1;
                        state_next     = ST_BUILD_RD;
                    end
                end
                else if (stat.i_one)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cmd.next_sort = 1'b1;
                    state_next    = ST_SWAP_RD;
                end
            end
            ST_SWAP_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = ST_SWAP_LD;
            end
            ST_SWAP_LD:
            begin
                cmd.swap_ld = 1'b1;
                state_next  = ST_SIFT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    cmd.emit_beat = 1'b1;
                    state_next    = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sorting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sorting_reg <= sorting_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT_WAIT);

endmodule

`default_nettype wire

// File: rtl/core/min_heap_sort_descending.sv
// ============================================================================
// min_heap_sort_descending
// Collects signed keys, heap-sorts them with a min-heap and streams them out
// in descending order.
//
// Input stream: one key per beat, tlast on the final key of a set. Keys are
// taken one per cycle while the block is loading; a key beyond 64 stored keys
// is dropped, but its tlast still starts the sort.
// Sorting runs from a single 64-entry RAM with two read ports: each sift-down
// level reads both children, then compares and writes back; each heap-build
// node and each root swap adds a read step and a load step. No input beat is
// taken from the final key until the last result.
// Output stream: one beat per stored key, each with the key, the total
// sift-level count of the sort (saturating at 1023) and tlast on the final key.
// Each beat is a RAM read, then a hold; the data holds while tready is low.
// Reset clears the key count and returns the block to loading; RAM contents
// are not cleared.
// ============================================================================
`default_nettype none

module min_heap_sort_descending
    import mhs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key_value
    input  wire logic                   s_axis_tlast,   // last_key
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // sorted_key, sift_steps
    output logic                        m_axis_tlast    // last_result
);

    mhs_cmd_t          cmd;
    mhs_stat_t         stat;
    logic [KEY_W-1:0]  out_key;
    logic [STEP_W-1:0] out_steps;

    mhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    mhs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_key    (s_axis_tdata[KEY_W-1:0]),
        .in_last   (s_axis_tlast),
        .out_key   (out_key),
        .out_steps (out_steps)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_steps, out_key});
    assign m_axis_tlast = stat.emit_last;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Streaming testbench for the min-heap descending sorter. Key sets are sent
// on the input stream. A behavioral heapsort predicts each untyped beat:
// the key, the sift-level count and tlast. Directed sets cover single keys,
// extremes, ties and mixed signs. Random sets follow, most of them small,
// a few at or beyond the 64-key store. Both sides stall at random.
// ============================================================================

module tb_top;
    import mhs_pkg::*;

    localparam int IDLE_LIMIT = 8000;
    localparam int KEY_BUDGET = 220;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [STEP_W-1:0] steps;
        logic              last;
    } sorted_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             typed;
        logic [KEY_W-1:0] exp_key;
    } stim_row_t;

    // typed rows are single-key sets: the key comes back with 0 steps and tlast
    localparam stim_row_t DIRECTED_ROWS [0:16] = '{
        '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'hffff_fffd, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{32'haaaa_aaaa, 1'b0, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{32'h1234_5678, 1'b1, 1'b0, 32'h0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;      // key_value
    logic                   s_axis_tlast = 1'b0;    // last_key
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // sorted_key, sift_steps
    logic                   m_axis_tlast;           // last_result

    logic signed [KEY_W-1:0] heap_keys [MAX_KEYS];
    int unsigned             key_total = 0;
    logic [STEP_W-1:0]       sort_steps = '0;
    sorted_beat_t            sorted_q [$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  keys_sent = 0;
    bit  steady = 1'b0;

    min_heap_sort_descending dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void sift_heap(input int size, input int node);
        int pick;
        int left;
        int right;
        logic signed [KEY_W-1:0] t;
        bit done;
        done = 1'b0;
        while (!done)
        begin
            pick  = node;
            left  = 2 * node + 1;
            right = 2 * node + 2;
            if (sort_steps != STEP_MAX)
                sort_steps = sort_steps + 1'b1;
            if (left < size && heap_keys[left] < heap_keys[pick])
                pick = left;
            if (right < size && heap_keys[right] < heap_keys[pick])
                pick = right;
            if (pick == node)
                done = 1'b1;
            else
            begin
                t               = heap_keys[node];
                heap_keys[node] = heap_keys[pick];
                heap_keys[pick] = t;
                node            = pick;
            end
        end
    endfunction

    // store one key; on tlast sort the set and queue its beats when record is set
    function automatic void predict_key(input logic [KEY_W-1:0] k, input logic l,
                                        input bit record);
        int n;
        logic signed [KEY_W-1:0] t;
        if (key_total < MAX_KEYS)
        begin
            heap_keys[key_total] = k;
            key_total++;
        end
        if (l)
        begin
            n = key_total;
            sort_steps = '0;
            for (int i = n / 2; i > 0; i--)
                sift_heap(n, i - 1);
            for (int i = n - 1; i > 0; i--)
            begin
                t            = heap_keys[0];
                heap_keys[0] = heap_keys[i];
                heap_keys[i] = t;
                sift_heap(i, 0);
            end
            if (record)
                for (int i = 0; i < n; i++)
                    sorted_q.push_back('{heap_keys[i], sort_steps, i == n - 1});
            key_total  = 0;
            sort_steps = '0;
        end
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] k, input logic l, input bit record);
        while (!steady && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_key(k, l, record);
        keys_sent++;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1:
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        sorted_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sorted_q.size() == 0)
                report_mismatch("beat with nothing pending", m_axis_tdata[KEY_W-1:0], '0);
            else
            begin
                want = sorted_q.pop_front();
                if (m_axis_tdata[KEY_W-1:0] !== want.key)
                    report_mismatch("sorted_key", m_axis_tdata[KEY_W-1:0], want.key);
                if (m_axis_tdata[KEY_W+STEP_W-1:KEY_W] !== want.steps)
                    report_mismatch("sift_steps", m_axis_tdata[KEY_W+STEP_W-1:KEY_W],
                                    want.steps);
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", m_axis_tlast, want.last);
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL min_heap_sort_descending");
            $finish;
        end
    end

    initial
    begin
        int size;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
        begin
            send_key(DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].last, !DIRECTED_ROWS[r].typed);
            if (DIRECTED_ROWS[r].typed)
                sorted_q.push_back('{DIRECTED_ROWS[r].exp_key, '0, 1'b1});
        end

        for (int s = 0; keys_sent < KEY_BUDGET; s++)
        begin
            steady = (s >= 3 && s < 9);
            if (s == 1)
                size = MAX_KEYS;
            else if (s == 2)
                size = MAX_KEYS + 3;
            else
            begin
                if ($urandom_range(9) == 0)
                    size = $urandom_range(40, 70);
                else
                    size = $urandom_range(1, 10);
                if (size > KEY_BUDGET - keys_sent)
                    size = KEY_BUDGET - keys_sent;
            end
            for (int k = 0; k < size; k++)
                send_key(rand_key(), k == size - 1, 1'b1);
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("PASS min_heap_sort_descending");
        else
            $display("FAIL min_heap_sort_descending");
        $finish;
    end
endmodule

// File: min_heap_sort_descending.f
rtl/core/mhs_pkg.sv
rtl/core/mhs_ram.sv
rtl/core/mhs_dp.sv
rtl/core/mhs_ctrl.sv
rtl/core/min_heap_sort_descending.sv
test/tb_top.sv
